// ----- hdl/k_combination_enumerator_unit_assert.svh -----
// Assertion macros for the k-combination enumerator.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef K_COMBINATION_ENUMERATOR_UNIT_ASSERT_SVH
`define K_COMBINATION_ENUMERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define KCE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kce assertion failed");

// next-cycle implication
`define KCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kce assertion failed");

`endif

// ----- hdl/kce_pkg.sv -----
// Package for the k-combination enumerator: field widths, defaults,
// register indexes and sequencer states. No dependencies.
package kce_pkg;

  localparam int POS_W     = 6;   // element index width
  localparam int N_W       = 7;   // set_size register width
  localparam int K_W       = 5;   // choose_count register width
  localparam int CFG_W     = 7;   // widest register
  localparam int DEF_MAX_K = 16;
  localparam int DEF_MAX_N = 64;

  typedef enum logic [0:0] {
    REG_SET_SIZE     = 1'b0,
    REG_CHOOSE_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REFILL,
    ST_EMIT,
    ST_EXH
  } kce_state_t;

endpackage

// ----- hdl/k_combination_enumerator_unit.sv -----
// Lexicographic k-combination enumerator, one request at a time.
// A first/restart request fills positions 0 to k-1, then k transfers; an
// advance scans down to the pivot, refills from it, then k transfers.
// A bad configuration, or a request past the last subset (full scan), gives
// an exhausted result. Output stalls hold transfers. One shared compare unit.
// Reset: n=1, k=1, first combination pending, no result held.
module k_combination_enumerator_unit #(
  parameter int MAX_K = kce_pkg::DEF_MAX_K,
  parameter int MAX_N = kce_pkg::DEF_MAX_N
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [kce_pkg::CFG_W-1:0] cfg_data,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      restart,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [kce_pkg::POS_W-1:0] index,
  output logic                      last_of_run,
  output logic                      more_left,
  output logic                      exhausted
);
  import kce_pkg::*;

  localparam int PW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  kce_state_t       state, state_next;
  logic [N_W-1:0]   set_size;
  logic [K_W-1:0]   choose_count;
  logic             first_pending, first_pending_next;
  logic [PW-1:0]    ptr, ptr_next;
  logic [POS_W-1:0] val, val_next;
  logic             more_acc, more_acc_next;
  logic [POS_W-1:0] positions [MAX_K];
  logic [POS_W-1:0] pos_rd;
  logic             pos_we;
  logic             res_valid_next;
  logic [POS_W-1:0] index_next;
  logic             last_next, more_next, exh_next;
  logic             cfg_ok, ptr_last;
  logic [7:0]       pmax, cmp_a;
  logic             cmp_eq;

  assign cfg_ok = (choose_count != '0) && ({1'b0, choose_count} <= 6'(MAX_K)) &&
                  (set_size != '0) && (9'(set_size) <= 9'(MAX_N)) &&
                  (7'(choose_count) <= set_size);

  assign pos_rd   = positions[ptr];
  assign ptr_last = (5'(ptr) == (choose_count - 5'd1));

  // shared unit: compare one value against the ceiling n-k+ptr
  assign pmax   = 8'(set_size) - 8'(choose_count) + 8'(ptr);
  assign cmp_a  = (state == ST_REFILL) ? 8'(val) : 8'(pos_rd);
  assign cmp_eq = (cmp_a == pmax);

  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      set_size      <= N_W'(1);
      choose_count  <= K_W'(1);
      first_pending <= 1'b1;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      first_pending <= first_pending_next;
      res_valid     <= res_valid_next;
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SET_SIZE:     set_size     <= cfg_data[N_W-1:0];
          REG_CHOOSE_COUNT: choose_count <= cfg_data[K_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr         <= ptr_next;
    val         <= val_next;
    more_acc    <= more_acc_next;
    index       <= index_next;
    last_of_run <= last_next;
    more_left   <= more_next;
    exhausted   <= exh_next;
    if (pos_we) begin
      positions[ptr] <= val;
    end
  end

  always_comb begin
    state_next         = state;
    first_pending_next = first_pending;
    ptr_next           = ptr;
    val_next           = val;
    more_acc_next      = more_acc;
    pos_we             = 1'b0;
    res_valid_next     = res_valid && res_stall;
    index_next         = index;
    last_next          = last_of_run;
    more_next          = more_left;
    exh_next           = exhausted;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (!cfg_ok) begin
            state_next = ST_EXH;
          end else if (restart || first_pending) begin
            first_pending_next = 1'b0;
            ptr_next           = '0;
            val_next           = '0;
            more_acc_next      = 1'b0;
            state_next         = ST_REFILL;
          end else begin
            ptr_next   = PW'(choose_count - 5'd1);
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // walk left to the rightmost position below its ceiling
        if (!cmp_eq) begin
          val_next      = pos_rd + POS_W'(1);
          more_acc_next = (ptr != '0);
          state_next    = ST_REFILL;
        end else if (ptr == '0) begin
          state_next = ST_EXH;
        end else begin
          ptr_next = ptr - PW'(1);
        end
      end
      ST_REFILL: begin
        pos_we        = 1'b1;
        more_acc_next = more_acc || !cmp_eq;
        val_next      = val + POS_W'(1);
        if (ptr_last) begin
          ptr_next   = '0;
          state_next = ST_EMIT;
        end else begin
          ptr_next = ptr + PW'(1);
        end
      end
      ST_EMIT: begin
        if (!res_valid || !res_stall) begin
          res_valid_next = 1'b1;
          index_next     = pos_rd;
          last_next      = ptr_last;
          more_next      = more_acc;
          exh_next       = 1'b0;
          if (ptr_last) begin
            state_next = ST_IDLE;
          end else begin
            ptr_next = ptr + PW'(1);
          end
        end
      end
      ST_EXH: begin
        if (!res_valid || !res_stall) begin
          res_valid_next = 1'b1;
          index_next     = '0;
          last_next      = 1'b1;
          more_next      = 1'b0;
          exh_next       = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (cfg_write) begin
      first_pending_next = 1'b1;
    end
  end

`include "k_combination_enumerator_unit_assert.svh"

  `KCE_ASSERT_NOW(a_exh_shape, res_valid && exhausted,
                  index == '0 && last_of_run && !more_left)
  `KCE_ASSERT_NEXT(a_bad_cfg_exh, req_valid && !req_stall && !cfg_ok, state == ST_EXH)
  `KCE_ASSERT_NOW(a_ptr_in_run, state == ST_EMIT || state == ST_REFILL,
                  5'(ptr) < choose_count)

endmodule
